/* src/ssps_pkg.sv */
package ssps_pkg;

  localparam int POS_W      = 32;
  localparam int HIST_D     = 17;
  localparam int RAW_D      = 6;
  localparam int PAT_N      = 12;
  localparam int PAT_MAXLEN = 18;
  localparam int PAT_W      = PAT_MAXLEN * 8;
  localparam int IDX_W      = $clog2(PAT_N);
  localparam int B64_LEN    = 7;
  localparam int FIFO_D     = 4;
  localparam int FPTR_W     = $clog2(FIFO_D);
  localparam int FCNT_W     = FPTR_W + 1;

  localparam logic [31:0] PAYLOAD_LIMIT_RST = 32'd1000;

  localparam logic [2:0] KIND_SCRIPT  = 3'd0;
  localparam logic [2:0] KIND_IFRAME  = 3'd1;
  localparam logic [2:0] KIND_JS_URI  = 3'd2;
  localparam logic [2:0] KIND_EVENT   = 3'd3;
  localparam logic [2:0] KIND_FOREIGN = 3'd4;
  localparam logic [2:0] KIND_DATA    = 3'd5;
  localparam logic [2:0] KIND_BASE64  = 3'd6;

  localparam logic SEV_CRITICAL = 1'b0;
  localparam logic SEV_WARNING  = 1'b1;

  localparam logic [1:0] CAT_XML      = 2'd0;
  localparam logic [1:0] CAT_SCRIPT   = 2'd1;
  localparam logic [1:0] CAT_METADATA = 2'd2;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef enum logic [1:0] {
    ONCE_NONE,
    ONCE_IFRAME,
    ONCE_JS,
    ONCE_FOREIGN
  } once_e;

  typedef enum logic [1:0] {
    B64_IDLE,
    B64_MEAS,
    B64_DONE
  } b64_phase_e;

  // last character sits in the lowest byte
  localparam logic [PAT_W-1:0] PAT_STR [PAT_N] = '{
    PAT_W'("<script"),
    PAT_W'("<iframe"),
    PAT_W'("javascript:"),
    PAT_W'("onload="),
    PAT_W'("onclick="),
    PAT_W'("onerror="),
    PAT_W'("onmouseover="),
    PAT_W'("onfocus="),
    PAT_W'("onblur="),
    PAT_W'("<foreignobject"),
    PAT_W'("data:text/html"),
    PAT_W'("data:image/svg+xml")
  };

  localparam logic [4:0] PAT_LEN [PAT_N] = '{
    5'd7, 5'd7, 5'd11, 5'd7, 5'd8, 5'd8, 5'd12, 5'd8, 5'd7, 5'd14, 5'd14, 5'd18
  };

  localparam logic [2:0] PAT_KIND [PAT_N] = '{
    KIND_SCRIPT, KIND_IFRAME, KIND_JS_URI, KIND_EVENT, KIND_EVENT, KIND_EVENT,
    KIND_EVENT, KIND_EVENT, KIND_EVENT, KIND_FOREIGN, KIND_DATA, KIND_DATA
  };

  localparam logic [1:0] PAT_CAT [PAT_N] = '{
    CAT_XML, CAT_XML, CAT_SCRIPT, CAT_SCRIPT, CAT_SCRIPT, CAT_SCRIPT,
    CAT_SCRIPT, CAT_SCRIPT, CAT_SCRIPT, CAT_XML, CAT_XML, CAT_XML
  };

  localparam logic [3:0] PAT_RLEN [PAT_N] = '{
    4'd7, 4'd7, 4'd11, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd14, 4'd10, 4'd10
  };

  localparam once_e PAT_ONCE [PAT_N] = '{
    ONCE_NONE, ONCE_IFRAME, ONCE_JS, ONCE_NONE, ONCE_NONE, ONCE_NONE,
    ONCE_NONE, ONCE_NONE, ONCE_NONE, ONCE_FOREIGN, ONCE_NONE, ONCE_NONE
  };

  localparam logic [B64_LEN*8-1:0] B64_MARK = "base64,";

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } hit_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] span;
  } b64_warn_t;

  typedef struct packed {
    logic        safe;
    logic [31:0] len;
    logic [31:0] start;
    logic [1:0]  cat;
    logic        sev;
    logic [2:0]  kind;
    logic        summary;
    logic        last;
  } res_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) ? (b | CASE_BIT) : b;
  endfunction

  function automatic logic is_term(input logic [7:0] b);
    return b == CH_DQUOTE || b == CH_SQUOTE || b == CH_LT || b == CH_GT ||
           b == CH_SPACE || b == CH_TAB || b == CH_LF;
  endfunction

  function automatic logic [31:0] to_out32(input logic [POS_W-1:0] v);
    logic [POS_W+31:0] w;
    w = {32'b0, v};
    return w[31:0];
  endfunction

endpackage

/* src/svg_script_pattern_scanner.sv */
// Channel   | Dir | Fields (tdata from bit 0 up)
// s_axis    | in  | tdata: data_byte[7:0]; tlast: final_byte
// m_axis    | out | tdata: issue_kind, severity, category, start_position,
//           |     |   match_length, doc_safe, pad; tuser: is_summary; tlast: last_result
// cfg       | in  | we + wdata: payload_limit
//
// One byte per cycle while tready is high; one word out per cycle unless m_axis stalls.
// A byte yields up to two words (issue plus summary on the final byte); a 4-word
// result FIFO takes them and tready drops while fewer than two slots are free.
// Pattern compares run in parallel on a row of 17 history cells.
// Async active-low reset; payload_limit resets to 1000.
module svg_script_pattern_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // kind[2:0] sev[3] cat[5:4] start[37:6]
                                        // len[69:38] safe[70] zero[71]
  output logic        m_axis_tuser_o,   // is_summary
  output logic        m_axis_tlast_o,   // last_result
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import ssps_pkg::*;

  logic             acc, fin;
  logic [7:0]       cur_raw, cur_fold;
  logic [7:0]       cell_raw  [HIST_D];
  logic [7:0]       cell_fold [HIST_D];
  logic [7:0]       raw_hist  [RAW_D];
  hit_t             hit;
  logic             mark;
  b64_warn_t        warn;

  logic [31:0]      limit_q;
  logic [POS_W-1:0] off_q, off_d;
  logic             seen_iframe_q, seen_js_q, seen_foreign_q;
  logic             any_crit_q;
  logic             blocked, emit_pat;
  logic [POS_W-1:0] pat_start;

  res_t              fifo_q [FIFO_D];
  logic [FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] cnt_q;
  logic [1:0]        wr_n;
  logic              pop;
  res_t              issue_r, sum_r, w0, w1, head;

  assign s_axis_tready_o = cnt_q <= FCNT_W'(FIFO_D - 2);
  assign acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign fin      = s_axis_tlast_i;
  assign cur_raw  = s_axis_tdata_i;
  assign cur_fold = fold(s_axis_tdata_i);

  genvar i;
  generate
    for (i = 0; i < HIST_D; i++) begin : g_cell
      ssps_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (acc),
        .clear_i (acc && fin),
        .d_i     ((i == 0) ? cur_raw : cell_raw[(i == 0) ? 0 : i - 1]),
        .raw_o   (cell_raw[i]),
        .fold_o  (cell_fold[i])
      );
    end
    for (i = 0; i < RAW_D; i++) begin : g_raw
      assign raw_hist[i] = cell_raw[i];
    end
  endgenerate

  ssps_match u_match (
    .cur_raw_i   (cur_raw),
    .cur_fold_i  (cur_fold),
    .fold_hist_i (cell_fold),
    .raw_hist_i  (raw_hist),
    .hit_o       (hit),
    .mark_o      (mark)
  );

  ssps_b64 u_b64 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .fin_i   (fin),
    .cur_i   (cur_raw),
    .mark_i  (mark),
    .off_i   (off_q),
    .limit_i (limit_q),
    .warn_o  (warn)
  );

  always_comb begin
    case (PAT_ONCE[hit.idx])
      ONCE_IFRAME:  blocked = seen_iframe_q;
      ONCE_JS:      blocked = seen_js_q;
      ONCE_FOREIGN: blocked = seen_foreign_q;
      default:      blocked = 1'b0;
    endcase
  end

  assign emit_pat  = acc && hit.valid && !blocked;
  assign pat_start = off_q - (POS_W'(PAT_LEN[hit.idx]) - POS_W'(1));

  // a pattern never ends on a terminator byte, so issue and warning are exclusive
  always_comb begin
    issue_r = '0;
    if (emit_pat) begin
      issue_r.kind  = PAT_KIND[hit.idx];
      issue_r.sev   = SEV_CRITICAL;
      issue_r.cat   = PAT_CAT[hit.idx];
      issue_r.start = to_out32(pat_start);
      issue_r.len   = {28'b0, PAT_RLEN[hit.idx]};
    end else begin
      issue_r.kind  = KIND_BASE64;
      issue_r.sev   = SEV_WARNING;
      issue_r.cat   = CAT_METADATA;
      issue_r.start = to_out32(warn.start);
      issue_r.len   = to_out32(warn.span);
    end
    issue_r.last = !fin;

    sum_r         = '0;
    sum_r.summary = 1'b1;
    sum_r.safe    = !(any_crit_q || emit_pat);
    sum_r.last    = 1'b1;

    w0   = (emit_pat || warn.valid) ? issue_r : sum_r;
    w1   = sum_r;
    wr_n = 2'd0;
    if (acc) begin
      wr_n = 2'({1'b0, emit_pat || warn.valid} + {1'b0, fin});
    end
  end

  assign off_d = (acc && fin) ? '0 : (acc ? off_q + POS_W'(1) : off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q        <= PAYLOAD_LIMIT_RST;
      off_q          <= '0;
      seen_iframe_q  <= 1'b0;
      seen_js_q      <= 1'b0;
      seen_foreign_q <= 1'b0;
      any_crit_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      off_q <= off_d;
      if (acc && fin) begin
        seen_iframe_q  <= 1'b0;
        seen_js_q      <= 1'b0;
        seen_foreign_q <= 1'b0;
        any_crit_q     <= 1'b0;
      end else if (emit_pat) begin
        any_crit_q <= 1'b1;
        if (PAT_ONCE[hit.idx] == ONCE_IFRAME) begin
          seen_iframe_q <= 1'b1;
        end
        if (PAT_ONCE[hit.idx] == ONCE_JS) begin
          seen_js_q <= 1'b1;
        end
        if (PAT_ONCE[hit.idx] == ONCE_FOREIGN) begin
          seen_foreign_q <= 1'b1;
        end
      end
    end
  end

  // result FIFO
  assign pop  = m_axis_tvalid_o && m_axis_tready_i;
  assign head = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= w0;
    end
    if (wr_n == 2'd2) begin
      fifo_q[wr_ptr_q + FPTR_W'(1)] <= w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FPTR_W'(wr_n);
      rd_ptr_q <= rd_ptr_q + FPTR_W'(pop);
      cnt_q    <= cnt_q + FCNT_W'(wr_n) - FCNT_W'(pop);
    end
  end

  assign m_axis_tvalid_o = cnt_q != '0;
  assign m_axis_tdata_o  = {1'b0, head.safe, head.len, head.start, head.cat, head.sev,
                            head.kind};
  assign m_axis_tuser_o  = head.summary;
  assign m_axis_tlast_o  = head.last;

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FCNT_W'(FIFO_D))
    else $error("result FIFO overflow");

  a_doc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && fin |=> off_q == '0 && !any_crit_q && !seen_iframe_q && !seen_js_q &&
    !seen_foreign_q)
    else $error("document state not cleared after final byte");

  a_crit_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_pat && !fin |=> any_crit_q)
    else $error("critical issue not recorded");

endmodule

/* src/ssps_cell.sv */
module ssps_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] d_i,
  output logic [7:0] raw_o,
  output logic [7:0] fold_o
);
  import ssps_pkg::*;

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = '0;
    end else if (shift_i) begin
      byte_d = d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign raw_o  = byte_q;
  assign fold_o = fold(byte_q);

endmodule

/* src/ssps_match.sv */
module ssps_match (
  input  logic [7:0]     cur_raw_i,
  input  logic [7:0]     cur_fold_i,
  input  logic [7:0]     fold_hist_i [ssps_pkg::HIST_D],
  input  logic [7:0]     raw_hist_i  [ssps_pkg::RAW_D],
  output ssps_pkg::hit_t hit_o,
  output logic           mark_o
);
  import ssps_pkg::*;

  logic [7:0]            win     [HIST_D+1];
  logic [7:0]            raw_win [RAW_D+1];
  logic [PAT_MAXLEN-1:0] eq      [PAT_N];
  logic [PAT_N-1:0]      pm;
  logic [B64_LEN-1:0]    meq;

  assign win[0]     = cur_fold_i;
  assign raw_win[0] = cur_raw_i;

  genvar k, p, j;
  generate
    for (k = 0; k < HIST_D; k++) begin : g_win
      assign win[k+1] = fold_hist_i[k];
    end
    for (k = 0; k < RAW_D; k++) begin : g_rwin
      assign raw_win[k+1] = raw_hist_i[k];
    end
    for (p = 0; p < PAT_N; p++) begin : g_pat
      for (j = 0; j < PAT_MAXLEN; j++) begin : g_chr
        assign eq[p][j] = (5'(j) < PAT_LEN[p]) ? (win[j] == PAT_STR[p][8*j +: 8]) : 1'b1;
      end
      assign pm[p] = &eq[p];
    end
    for (j = 0; j < B64_LEN; j++) begin : g_mark
      assign meq[j] = raw_win[j] == B64_MARK[8*j +: 8];
    end
  endgenerate

  assign mark_o = &meq;

  always_comb begin
    hit_o.valid = |pm;
    hit_o.idx   = '0;
    for (int i = PAT_N - 1; i >= 0; i--) begin
      if (pm[i]) begin
        hit_o.idx = IDX_W'(i);
      end
    end
  end

endmodule

/* src/ssps_b64.sv */
module ssps_b64 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  logic                      fin_i,
  input  logic [7:0]                cur_i,
  input  logic                      mark_i,
  input  logic [ssps_pkg::POS_W-1:0] off_i,
  input  logic [31:0]               limit_i,
  output ssps_pkg::b64_warn_t       warn_o
);
  import ssps_pkg::*;

  b64_phase_e       phase_q, phase_d;
  logic [POS_W-1:0] span_q, span_d;
  logic [POS_W-1:0] start_q, start_d;
  logic             term, over;

  assign term = is_term(cur_i);
  assign over = {{32{1'b0}}, span_q} > {{POS_W{1'b0}}, limit_i};

  always_comb begin
    phase_d = phase_q;
    span_d  = span_q;
    start_d = start_q;
    if (acc_i) begin
      if (fin_i) begin
        phase_d = B64_IDLE;
        span_d  = '0;
        start_d = '0;
      end else begin
        case (phase_q)
          B64_IDLE: begin
            if (mark_i) begin
              phase_d = B64_MEAS;
              span_d  = POS_W'(B64_LEN);
              start_d = off_i - POS_W'(B64_LEN - 1);
            end
          end
          B64_MEAS: begin
            span_d = span_q + POS_W'(1);
            if (term) begin
              phase_d = B64_DONE;
            end
          end
          B64_DONE: phase_d = B64_DONE;
          default:  phase_d = B64_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    warn_o.valid = acc_i && (phase_q == B64_MEAS) && term && over;
    warn_o.start = start_q;
    warn_o.span  = span_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= B64_IDLE;
      span_q  <= '0;
      start_q <= '0;
    end else begin
      phase_q <= phase_d;
      span_q  <= span_d;
      start_q <= start_d;
    end
  end

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && fin_i |=> phase_q == B64_IDLE && span_q == '0)
    else $error("base64 tracker not cleared at end of document");

  a_meas_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !fin_i && phase_q == B64_IDLE && mark_i |=> phase_q == B64_MEAS &&
    span_q == POS_W'(B64_LEN))
    else $error("base64 span not started on mark");

endmodule

/* tb/tb_svg_script_pattern_scanner.sv */
module tb_svg_script_pattern_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import ssps_pkg::*;

  localparam int SIG_N        = 12;
  localparam int HIST_LEN     = 17;
  localparam int PHASE_ITEMS  = 250;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_N        = 8;

  typedef struct packed {
    logic [2:0]  kind;
    logic        sev;
    logic [1:0]  cat;
    logic [31:0] start;
    logic [31:0] len;
    logic        summary;
    logic        safe;
    logic        last;
  } scan_word_t;

  typedef logic [7:0] hist_t [HIST_LEN];

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data    = '0;
  logic        s_last    = 1'b0;
  logic        m_valid;
  logic        m_ready   = 1'b0;
  logic [71:0] m_data;
  logic        m_user;
  logic        m_last;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  svg_script_pattern_scanner u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // signature table, folded text
  string sig_text [SIG_N] = '{"<script", "<iframe", "javascript:", "onload=", "onclick=",
    "onerror=", "onmouseover=", "onfocus=", "onblur=", "<foreignobject", "data:text/html",
    "data:image/svg+xml"};
  logic [2:0] sig_kind [SIG_N] = '{KIND_SCRIPT, KIND_IFRAME, KIND_JS_URI, KIND_EVENT,
    KIND_EVENT, KIND_EVENT, KIND_EVENT, KIND_EVENT, KIND_EVENT, KIND_FOREIGN, KIND_DATA,
    KIND_DATA};
  logic [1:0] sig_cat [SIG_N] = '{CAT_XML, CAT_XML, CAT_SCRIPT, CAT_SCRIPT, CAT_SCRIPT,
    CAT_SCRIPT, CAT_SCRIPT, CAT_SCRIPT, CAT_SCRIPT, CAT_XML, CAT_XML, CAT_XML};
  logic [31:0] sig_rlen [SIG_N] = '{32'd7, 32'd7, 32'd11, 32'd7, 32'd7, 32'd7, 32'd7,
    32'd7, 32'd7, 32'd14, 32'd10, 32'd10};
  once_e sig_once [SIG_N] = '{ONCE_NONE, ONCE_IFRAME, ONCE_JS, ONCE_NONE, ONCE_NONE,
    ONCE_NONE, ONCE_NONE, ONCE_NONE, ONCE_NONE, ONCE_FOREIGN, ONCE_NONE, ONCE_NONE};
  string b64_tag = "base64,";
  logic [7:0] stop_chars [7] = '{CH_DQUOTE, CH_SQUOTE, CH_LT, CH_GT, CH_SPACE, CH_TAB,
    CH_LF};

  // directed rows; typed count -1 means the scanner model supplies the words
  string dir_text [DIR_N] = '{"<script", "\377", "<scr", "ipt", "<iframe<IFRAME",
    "base64,a\"x", "BASE64,base64,z", " onblur="};
  bit dir_fin [DIR_N]   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  int dir_typed [DIR_N] = '{2, 1, -1, -1, -1, -1, -1, -1};
  scan_word_t dir_words [3] = '{
    '{KIND_SCRIPT, SEV_CRITICAL, CAT_XML, 32'd0, 32'd7, 1'b0, 1'b0, 1'b0},
    '{3'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1},
    '{3'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1}
  };

  int idle_plan  [4] = '{0, 54, 0, 30};
  int stall_plan [4] = '{0, 0, 54, 30};

  // scanner model state
  logic [31:0] limit_model;
  logic [31:0] doc_offset;
  hist_t       fold_hist;
  hist_t       raw_hist;
  logic [3:0]  once_seen;
  b64_phase_e  b64_state;
  logic [31:0] b64_origin;
  logic        critical_seen;
  scan_word_t  pred_word [2];
  int          pred_n;
  scan_word_t  scan_expect_q [$];

  logic [7:0] doc_q [$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int bytes_sent     = 0;
  int stall_cycles   = 0;
  int long_left      = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void doc_clear();
    doc_offset    = '0;
    fold_hist     = '{default: '0};
    raw_hist      = '{default: '0};
    once_seen     = '0;
    b64_state     = B64_IDLE;
    b64_origin    = '0;
    critical_seen = 1'b0;
  endfunction

  // hist[0] is the byte just before cur
  function automatic bit tail_match(string pat, logic [7:0] cur, hist_t hist);
    int n;
    int i;
    n = pat.len();
    if (pat[n-1] != cur) return 1'b0;
    for (i = 0; i + 1 < n; i++)
      if (pat[n-2-i] != hist[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_word(logic [2:0] code, logic sev_v, logic [1:0] cat_v,
                                   logic [31:0] pos, logic [31:0] span);
    if (pred_n < 2) begin
      pred_word[pred_n] = '{kind: code, sev: sev_v, cat: cat_v, start: pos, len: span,
                            summary: 1'b0, safe: 1'b0, last: 1'b0};
      pred_n++;
    end
  endfunction

  function automatic void scan_predict(logic [7:0] b, logic fin);
    logic [7:0]  f;
    logic [31:0] span;
    bit          hit;
    int          p;
    f = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    pred_n = 0;
    hit = 1'b0;
    for (p = 0; p < SIG_N && !hit; p++) begin
      if (tail_match(sig_text[p], f, fold_hist)) begin
        hit = 1'b1;
        if (sig_once[p] == ONCE_NONE || !once_seen[sig_once[p]]) begin
          once_seen[sig_once[p]] = 1'b1;
          add_word(sig_kind[p], SEV_CRITICAL, sig_cat[p],
                   doc_offset - 32'(sig_text[p].len() - 1), sig_rlen[p]);
          critical_seen = 1'b1;
        end
      end
    end
    if (b64_state == B64_MEAS) begin
      if (b inside {CH_DQUOTE, CH_SQUOTE, CH_LT, CH_GT, CH_SPACE, CH_TAB, CH_LF}) begin
        span = doc_offset - b64_origin;
        if (span > limit_model)
          add_word(KIND_BASE64, SEV_WARNING, CAT_METADATA, b64_origin, span);
        b64_state = B64_DONE;
      end
    end else if (b64_state == B64_IDLE && tail_match(b64_tag, b, raw_hist)) begin
      b64_origin = doc_offset - 32'd6;
      b64_state  = B64_MEAS;
    end
    for (p = HIST_LEN - 1; p > 0; p--) begin
      fold_hist[p] = fold_hist[p-1];
      raw_hist[p]  = raw_hist[p-1];
    end
    fold_hist[0] = f;
    raw_hist[0]  = b;
    doc_offset++;
    if (fin) begin
      if (pred_n > 1) pred_n = 1;
      pred_word[pred_n] = '{kind: '0, sev: '0, cat: '0, start: '0, len: '0,
                            summary: 1'b1, safe: !critical_seen, last: 1'b0};
      pred_n++;
      doc_clear();
    end
    if (pred_n > 0) pred_word[pred_n-1].last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin, bit record);
    int k;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= fin;
    do @(posedge clk); while (!s_ready);
    scan_predict(b, fin);
    if (record)
      for (k = 0; k < pred_n; k++) scan_expect_q = {scan_expect_q, pred_word[k]};
    bytes_sent++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (scan_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(logic [31:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_model = v;
  endtask

  function automatic void put_text(string s, bit mix_case);
    logic [7:0] c;
    int i;
    for (i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
          $urandom_range(0, 1) == 1)
        c = c ^ 8'h20;
      doc_q = {doc_q, c};
    end
  endfunction

  task automatic random_doc();
    string s;
    int    nfrag;
    int    i;
    int    plen;
    doc_q.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 16)) doc_q = {doc_q, 8'($urandom_range(0, 255))};
    end else begin
      nfrag = $urandom_range(1, 6);
      for (i = 0; i < nfrag; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: put_text(sig_text[$urandom_range(0, SIG_N - 1)], 1'b1);
          3: begin
            s = sig_text[$urandom_range(0, SIG_N - 1)];
            put_text(s.substr(0, $urandom_range(0, s.len() - 2)), 1'b1);
          end
          4: begin
            put_text("data:", 1'b1);
            case ($urandom_range(0, 3))
              0: doc_q = {doc_q, stop_chars[$urandom_range(0, 6)]};
              1: doc_q = {doc_q, 8'($urandom_range(0, 255))};
              default: ;
            endcase
            if ($urandom_range(0, 1) == 1) put_text("text/html", 1'b1);
            else put_text("image/svg+xml", 1'b1);
          end
          5, 6: begin
            put_text(b64_tag, $urandom_range(0, 5) == 0);
            if (long_left > 0 && limit_model > 64 && limit_model <= 4096) begin
              plen = int'(limit_model) - 9 + $urandom_range(0, 4);
              long_left--;
            end else if (limit_model <= 64) begin
              plen = $urandom_range(0, int'(limit_model) + 2);
            end else begin
              plen = $urandom_range(0, 10);
            end
            repeat (plen) doc_q = {doc_q, 8'($urandom_range(8'h3f, 8'h7e))};
            if ($urandom_range(0, 7) != 0) doc_q = {doc_q, stop_chars[$urandom_range(0, 6)]};
          end
          7: repeat ($urandom_range(1, 4)) doc_q = {doc_q, 8'($urandom_range(0, 255))};
          8: doc_q = {doc_q, stop_chars[$urandom_range(0, 6)]};
          default: repeat ($urandom_range(1, 6))
            doc_q = {doc_q, 8'($urandom_range(8'h20, 8'h7e))};
        endcase
      end
    end
    for (i = 0; i < doc_q.size(); i++)
      send_byte(doc_q[i], i == doc_q.size() - 1, 1'b1);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    scan_word_t got;
    scan_word_t want;
    if (rst_n && m_valid && m_ready) begin
      got = '{kind: m_data[2:0], sev: m_data[3], cat: m_data[5:4], start: m_data[37:6],
              len: m_data[69:38], summary: m_user, safe: m_data[70], last: m_last};
      if (scan_expect_q.size() == 0) begin
        $error("result word with nothing expected: %h", m_data);
        errors++;
      end else begin
        want = scan_expect_q.pop_front();
        check_field("issue_kind", 32'(want.kind), 32'(got.kind));
        check_field("severity", 32'(want.sev), 32'(got.sev));
        check_field("category", 32'(want.cat), 32'(got.cat));
        check_field("start_position", want.start, got.start);
        check_field("match_length", want.len, got.len);
        check_field("is_summary", 32'(want.summary), 32'(got.summary));
        check_field("doc_safe", 32'(want.safe), 32'(got.safe));
        check_field("last_result", 32'(want.last), 32'(got.last));
      end
    end
    m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int row;
    int w;
    int i;
    int ph;
    int phase_base;
    doc_clear();
    limit_model = PAYLOAD_LIMIT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    w = 0;
    for (row = 0; row < DIR_N; row++) begin
      for (i = 0; i < dir_typed[row]; i++) begin
        scan_expect_q = {scan_expect_q, dir_words[w]};
        w++;
      end
      for (i = 0; i < dir_text[row].len(); i++)
        send_byte(dir_text[row][i], dir_fin[row] && i == dir_text[row].len() - 1,
                  dir_typed[row] < 0);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        1: set_limit(32'd0);
        2: set_limit(32'hFFFF_FFFF);
        3: set_limit(32'($urandom_range(1, 40)));
        default: long_left = 2;
      endcase
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      phase_base = bytes_sent;
      while (bytes_sent - phase_base < PHASE_ITEMS) random_doc();
    end

    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
src/ssps_pkg.sv
src/ssps_cell.sv
src/ssps_match.sv
src/ssps_b64.sv
src/svg_script_pattern_scanner.sv
tb/tb_svg_script_pattern_scanner.sv
